/* rtl/core/ost_pkg.sv */
// ----------------------------------------------------------------------------
// ost_pkg
// Types, codes and helpers shared by the order state table blocks.
// ----------------------------------------------------------------------------
package ost_pkg;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_FILL   = 2'd3;

    localparam logic [2:0] KIND_NEW_ACK    = 3'd0;
    localparam logic [2:0] KIND_CANCEL_ACK = 3'd1;
    localparam logic [2:0] KIND_MODIFY_ACK = 3'd2;
    localparam logic [2:0] KIND_REJECT     = 3'd3;
    localparam logic [2:0] KIND_FILL       = 3'd4;
    localparam logic [2:0] KIND_FILL_DROP  = 3'd5;

    localparam logic [2:0] RSN_DUPLICATE  = 3'd0;
    localparam logic [2:0] RSN_UNKNOWN    = 3'd1;
    localparam logic [2:0] RSN_INSTRUMENT = 3'd2;
    localparam logic [2:0] RSN_SIDE       = 3'd3;
    localparam logic [2:0] RSN_PRICE      = 3'd4;
    localparam logic [2:0] RSN_QUANTITY   = 3'd5;
    localparam logic [2:0] RSN_TERMINAL   = 3'd6;
    localparam logic [2:0] RSN_FULL       = 3'd7;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_PARTIAL   = 3'd1;
    localparam logic [2:0] ST_FILLED    = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    localparam logic [1:0]  SIDE_BID     = 2'd1;
    localparam logic [1:0]  SIDE_ASK     = 2'd2;
    localparam logic [31:0] PRICE_UNDEF  = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  eng;
        logic [31:0] oid;
        logic [15:0] inst;
        logic [1:0]  side;
        logic [31:0] price;
        logic [31:0] size;
        logic [63:0] ts;
        logic        fill_live;
        logic        bad_inst;
        logic        bad_side;
        logic        bad_price;
        logic        zero_size;
    } t_cmd;

    typedef struct packed {
        logic [15:0] inst;
        logic [1:0]  side;
        logic [31:0] price;
        logic [31:0] orig;
        logic [31:0] rem;
        logic [2:0]  status;
        logic [63:0] ts;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reason;
        logic [2:0]  status;
        logic [2:0]  eng;
        logic [31:0] oid;
        logic [15:0] inst;
        logic [1:0]  side;
        logic [31:0] price;
        logic [31:0] orig;
        logic [31:0] rem;
        logic [31:0] fprice;
        logic [31:0] fsize;
    } t_rsp;

    function automatic logic is_terminal(input logic [2:0] st);
        return (st == ST_FILLED) || (st == ST_CANCELLED) || (st == ST_REJECTED);
    endfunction

endpackage

/* rtl/core/ost_if.sv */
// ----------------------------------------------------------------------------
// ost_if
// Request, response and configuration channels of the order state table.
// ----------------------------------------------------------------------------
interface ost_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [2:0]         engine_id;
    logic [31:0]        order_ref;
    logic [15:0]        instr_code;
    logic [1:0]         side;
    logic signed [31:0] price;
    logic [31:0]        size;
    logic [63:0]        timestamp;

    modport source (output valid, operation, engine_id, order_ref, instr_code, side,
                    price, size, timestamp, input ready);
    modport sink   (input valid, operation, engine_id, order_ref, instr_code, side,
                    price, size, timestamp, output ready);
endinterface

interface ost_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         response_kind;
    logic [2:0]         rej_code;
    logic [2:0]         order_status;
    logic [2:0]         out_engine_id;
    logic [31:0]        out_order_ref;
    logic [15:0]        out_instr_code;
    logic [1:0]         out_side;
    logic signed [31:0] order_price;
    logic [31:0]        orig_qty;
    logic [31:0]        open_qty;
    logic signed [31:0] exec_price;
    logic [31:0]        exec_qty;

    modport source (output valid, response_kind, rej_code, order_status,
                    out_engine_id, out_order_ref, out_instr_code, out_side,
                    order_price, orig_qty, open_qty, exec_price,
                    exec_qty, input ready);
    modport sink   (input valid, response_kind, rej_code, order_status,
                    out_engine_id, out_order_ref, out_instr_code, out_side,
                    order_price, orig_qty, open_qty, exec_price,
                    exec_qty, output ready);
endinterface

interface ost_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] engine_enabled;

    modport source (output valid, engine_enabled, input ready);
    modport sink   (input valid, engine_enabled, output ready);
endinterface

/* rtl/core/order_state_table.sv */
// ----------------------------------------------------------------------------
// order_state_table
// Order table keyed by engine and order id: new, cancel, modify and fill.
//
//   channel  dir  carries
//   i_req    in   one request item per handshake
//   o_rsp    out  at most one response item per request
//   i_cfg    in   engine enable mask, always ready
//
// The table engine takes one item at a time: pop, key compares up to the match,
// at most the fill count, then execute; fills of zero size or from disabled
// engines skip the scan. A stalled response holds the engine in execute; a
// two-entry queue lets intake run ahead until it fills.
// Reset clears the fill count; no clearing pass over the table is needed.
// ----------------------------------------------------------------------------
module order_state_table #(
    parameter int TABLE_DEPTH  = 256,
    parameter int ENGINE_COUNT = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ost_req_if.sink   i_req,
    ost_cfg_if.sink   i_cfg,
    ost_rsp_if.source o_rsp
);
    import ost_pkg::*;

    logic [7:0] r_engine_enabled;
    logic       push;
    logic       full;
    logic       q_valid;
    logic       pop;
    t_cmd       cmd_in;
    t_cmd       cmd_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engine_enabled <= '0;
        end else if (i_cfg.valid) begin
            r_engine_enabled <= i_cfg.engine_enabled;
        end
    end

    ost_front #(.ENGINE_COUNT(ENGINE_COUNT)) u_front (
        .i_req            (i_req),
        .i_engine_enabled (r_engine_enabled),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (cmd_in)
    );

    ost_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (cmd_out)
    );

    ost_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd_v (q_valid),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

/* rtl/core/ost_front.sv */
// ----------------------------------------------------------------------------
// ost_front
// Request intake: drop non-fill requests of disabled engines, precheck fields, queue commands.
// ----------------------------------------------------------------------------
module ost_front #(
    parameter int ENGINE_COUNT = 8
) (
    ost_req_if.sink      i_req,
    input  logic [7:0]   i_engine_enabled,
    input  logic         i_full,
    output logic         o_push,
    output ost_pkg::t_cmd o_cmd
);
    import ost_pkg::*;

    logic enabled;

    assign enabled = ({29'd0, i_req.engine_id} < 32'(ENGINE_COUNT))
                     && i_engine_enabled[i_req.engine_id];

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full && (i_req.operation == OP_FILL || enabled);

    always_comb begin
        o_cmd.op        = i_req.operation;
        o_cmd.eng       = i_req.engine_id;
        o_cmd.oid       = i_req.order_ref;
        o_cmd.inst      = i_req.instr_code;
        o_cmd.side      = i_req.side;
        o_cmd.price     = i_req.price;
        o_cmd.size      = i_req.size;
        o_cmd.ts        = i_req.timestamp;
        o_cmd.fill_live = enabled && (i_req.size != 32'd0);
        o_cmd.bad_inst  = (i_req.instr_code == 16'd0);
        o_cmd.bad_side  = !(i_req.side == SIDE_BID || i_req.side == SIDE_ASK);
        o_cmd.bad_price = (i_req.price == PRICE_UNDEF);
        o_cmd.zero_size = (i_req.size == 32'd0);
    end

endmodule

/* rtl/core/ost_queue.sv */
// ----------------------------------------------------------------------------
// ost_queue
// Two-entry command queue between intake and table engine.
// ----------------------------------------------------------------------------
module ost_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ost_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ost_pkg::t_cmd o_cmd
);
    import ost_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* rtl/core/ost_back.sv */
// ----------------------------------------------------------------------------
// ost_back
// Table engine: key scan, entry read-modify-write and response register.
// ----------------------------------------------------------------------------
module ost_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_v,
    input  ost_pkg::t_cmd i_cmd,
    output logic          o_pop,
    ost_rsp_if.source     o_rsp
);
    import ost_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [IW-1:0] r_idx;
    logic        r_found;
    logic [CW-1:0] r_count;
    logic [34:0] r_key_q;
    t_entry      r_ent_q;
    logic        r_out_v;
    t_rsp        r_rsp;

    logic [34:0] mem_key [TABLE_DEPTH];
    t_entry      mem_ent [TABLE_DEPTH];

    logic [IW-1:0] key_addr;
    logic          key_hit;
    logic          scan_last;
    logic          out_free;
    logic          need_scan;
    logic          fire;
    logic          rej;
    logic [2:0]    rsn;
    logic          wr_ent;
    logic          wr_key;
    logic [IW-1:0] wr_addr;
    t_entry        n_ent;
    t_rsp          n_rsp;
    logic [31:0]   take;
    logic [31:0]   left;
    logic          term;

    assign key_addr  = (r_state == S_IDLE) ? '0 : r_idx + 1'b1;
    assign key_hit   = (r_key_q == {r_cmd.eng, r_cmd.oid});
    assign scan_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign out_free  = !r_out_v || o_rsp.ready;
    assign need_scan = (i_cmd.op != OP_FILL) || i_cmd.fill_live;
    assign o_pop     = (r_state == S_IDLE) && i_cmd_v;
    assign fire      = (r_state == S_EXEC) && out_free;
    assign term      = r_found && is_terminal(r_ent_q.status);
    assign take      = (r_cmd.size < r_ent_q.rem) ? r_cmd.size : r_ent_q.rem;
    assign left      = r_ent_q.rem - take;

    always_comb begin
        rej    = 1'b0;
        rsn    = RSN_DUPLICATE;
        wr_ent = 1'b0;
        wr_key = 1'b0;
        wr_addr = r_idx;
        n_ent  = r_ent_q;
        n_ent.ts = r_cmd.ts;
        n_rsp  = '0;
        n_rsp.eng  = r_cmd.eng;
        n_rsp.oid  = r_cmd.oid;
        n_rsp.inst = r_cmd.inst;
        n_rsp.side = r_cmd.side;
        n_rsp.price = r_cmd.price;
        case (r_cmd.op)
            OP_FILL: begin
                if (!r_cmd.fill_live || !r_found || term) begin
                    n_rsp.kind   = KIND_FILL_DROP;
                    n_rsp.status = ST_REJECTED;
                    n_rsp.inst   = '0;
                    n_rsp.side   = '0;
                    n_rsp.price  = '0;
                end else begin
                    wr_ent       = 1'b1;
                    n_ent.rem    = left;
                    n_ent.status = (left == 32'd0) ? ST_FILLED : ST_PARTIAL;
                    n_rsp.kind   = KIND_FILL;
                    n_rsp.status = n_ent.status;
                    n_rsp.inst   = r_ent_q.inst;
                    n_rsp.side   = r_ent_q.side;
                    n_rsp.price  = r_ent_q.price;
                    n_rsp.orig   = r_ent_q.orig;
                    n_rsp.rem    = left;
                    n_rsp.fprice = r_cmd.price;
                    n_rsp.fsize  = take;
                end
            end
            OP_NEW: begin
                rej = 1'b1;
                if (r_found) rsn = RSN_DUPLICATE;
                else if (r_cmd.bad_inst) rsn = RSN_INSTRUMENT;
                else if (r_cmd.bad_side) rsn = RSN_SIDE;
                else if (r_cmd.bad_price) rsn = RSN_PRICE;
                else if (r_cmd.zero_size) rsn = RSN_QUANTITY;
                else if (r_count == CW'(TABLE_DEPTH)) rsn = RSN_FULL;
                else rej = 1'b0;
                wr_addr = r_count[IW-1:0];
                wr_ent  = !rej;
                wr_key  = !rej;
                n_ent.inst   = r_cmd.inst;
                n_ent.side   = r_cmd.side;
                n_ent.price  = r_cmd.price;
                n_ent.orig   = r_cmd.size;
                n_ent.rem    = r_cmd.size;
                n_ent.status = ST_ACCEPTED;
                n_rsp.kind   = KIND_NEW_ACK;
                n_rsp.status = ST_ACCEPTED;
                n_rsp.orig   = r_cmd.size;
                n_rsp.rem    = r_cmd.size;
            end
            OP_CANCEL: begin
                rej = 1'b1;
                if (!r_found) rsn = RSN_UNKNOWN;
                else if (term) rsn = RSN_TERMINAL;
                else rej = 1'b0;
                wr_ent       = !rej;
                n_ent.status = ST_CANCELLED;
                n_rsp.kind   = KIND_CANCEL_ACK;
                n_rsp.status = ST_CANCELLED;
                n_rsp.orig   = r_ent_q.orig;
                n_rsp.rem    = r_ent_q.rem;
            end
            default: begin
                rej = 1'b1;
                if (!r_found) rsn = RSN_UNKNOWN;
                else if (term) rsn = RSN_TERMINAL;
                else if (r_cmd.bad_side) rsn = RSN_SIDE;
                else if (r_cmd.bad_price) rsn = RSN_PRICE;
                else if (r_cmd.zero_size) rsn = RSN_QUANTITY;
                else rej = 1'b0;
                wr_ent       = !rej;
                n_ent.side   = r_cmd.side;
                n_ent.price  = r_cmd.price;
                n_ent.orig   = r_cmd.size;
                n_ent.rem    = r_cmd.size;
                n_ent.status = ST_ACCEPTED;
                n_rsp.kind   = KIND_MODIFY_ACK;
                n_rsp.status = ST_ACCEPTED;
                n_rsp.orig   = r_cmd.size;
                n_rsp.rem    = r_cmd.size;
            end
        endcase
        if (rej) begin
            n_rsp.kind   = KIND_REJECT;
            n_rsp.reason = rsn;
            n_rsp.status = ST_REJECTED;
            n_rsp.orig   = r_cmd.size;
            n_rsp.rem    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_q <= mem_key[key_addr];
        r_ent_q <= mem_ent[r_idx];
        if (fire && wr_ent) begin
            mem_ent[wr_addr] <= n_ent;
        end
        if (fire && wr_key) begin
            mem_key[wr_addr] <= {r_cmd.eng, r_cmd.oid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_v <= 1'b0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_v) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (need_scan && r_count != '0) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    if (key_hit) begin
                        r_found <= 1'b1;
                        r_state <= S_EXEC;
                    end else if (scan_last) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_rsp   <= n_rsp;
                        if (wr_key) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.response_kind  = r_rsp.kind;
    assign o_rsp.rej_code       = r_rsp.reason;
    assign o_rsp.order_status   = r_rsp.status;
    assign o_rsp.out_engine_id  = r_rsp.eng;
    assign o_rsp.out_order_ref  = r_rsp.oid;
    assign o_rsp.out_instr_code = r_rsp.inst;
    assign o_rsp.out_side       = r_rsp.side;
    assign o_rsp.order_price    = r_rsp.price;
    assign o_rsp.orig_qty       = r_rsp.orig;
    assign o_rsp.open_qty       = r_rsp.rem;
    assign o_rsp.exec_price     = r_rsp.fprice;
    assign o_rsp.exec_qty       = r_rsp.fsize;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives order requests into order_state_table and checks every response
// against an in-bench order table under several engine masks and idling.
// ----------------------------------------------------------------------------
module testbench;
    import ost_pkg::*;

    localparam int DEPTH = 256;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  eng;
        logic [31:0] oid;
        logic [15:0] inst;
        logic [1:0]  side;
        logic [31:0] price;
        logic [31:0] size;
        logic [63:0] ts;
    } t_item;

    typedef struct {
        t_item item;
        logic  has_rsp;
        logic  typed;
        t_rsp  rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ost_req_if req_ch ();
    ost_rsp_if rsp_ch ();
    ost_cfg_if cfg_ch ();

    order_state_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #4 i_clk = ~i_clk;

    logic [7:0]  eng_mask;
    logic        tbl_valid [DEPTH];
    logic [2:0]  tbl_eng [DEPTH];
    logic [31:0] tbl_oid [DEPTH];
    logic [15:0] tbl_inst [DEPTH];
    logic [1:0]  tbl_side [DEPTH];
    logic [31:0] tbl_price [DEPTH];
    logic [31:0] tbl_orig [DEPTH];
    logic [31:0] tbl_rem [DEPTH];
    logic [2:0]  tbl_status [DEPTH];
    int          tbl_used;

    t_rsp  pending_rsp [$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    send_idle = 0;
    int    recv_stall = 0;
    logic  [31:0] known_oid [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int lookup_order(input logic [2:0] eng, input logic [31:0] oid);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_eng[i] == eng && tbl_oid[i] == oid) return i;
        return -1;
    endfunction

    function automatic t_rsp zero_rsp(input logic [2:0] kind, input logic [2:0] st,
                                      input t_item it);
        t_rsp r;
        r = '0;
        r.kind = kind;
        r.status = st;
        r.eng = it.eng;
        r.oid = it.oid;
        return r;
    endfunction

    // Returns 1 when the request yields a response.
    function automatic logic apply_request(input t_item it, output t_rsp r);
        logic        en;
        int          s;
        logic [2:0]  rsn;
        logic        bad;
        logic [31:0] take;
        en = eng_mask[it.eng];
        r = '0;
        if (it.op == OP_FILL) begin
            s = -1;
            if (it.size != 0 && en) s = lookup_order(it.eng, it.oid);
            if (s < 0 || is_terminal(tbl_status[s])) begin
                r = zero_rsp(KIND_FILL_DROP, ST_REJECTED, it);
                return 1'b1;
            end
            take = it.size < tbl_rem[s] ? it.size : tbl_rem[s];
            tbl_rem[s] -= take;
            tbl_status[s] = tbl_rem[s] == 0 ? ST_FILLED : ST_PARTIAL;
            r.kind = KIND_FILL; r.status = tbl_status[s];
            r.eng = tbl_eng[s]; r.oid = tbl_oid[s]; r.inst = tbl_inst[s];
            r.side = tbl_side[s]; r.price = tbl_price[s]; r.orig = tbl_orig[s];
            r.rem = tbl_rem[s]; r.fprice = it.price; r.fsize = take;
            return 1'b1;
        end
        if (!en) return 1'b0;
        s = lookup_order(it.eng, it.oid);
        bad = 1'b1;
        rsn = RSN_DUPLICATE;
        if (it.op == OP_NEW) begin
            if (s >= 0) rsn = RSN_DUPLICATE;
            else if (it.inst == 0) rsn = RSN_INSTRUMENT;
            else if (it.side != SIDE_BID && it.side != SIDE_ASK) rsn = RSN_SIDE;
            else if (it.price == PRICE_UNDEF) rsn = RSN_PRICE;
            else if (it.size == 0) rsn = RSN_QUANTITY;
            else if (tbl_used >= DEPTH) rsn = RSN_FULL;
            else bad = 1'b0;
        end else begin
            if (s < 0) rsn = RSN_UNKNOWN;
            else if (is_terminal(tbl_status[s])) rsn = RSN_TERMINAL;
            else if (it.op == OP_MODIFY && it.side != SIDE_BID && it.side != SIDE_ASK)
                rsn = RSN_SIDE;
            else if (it.op == OP_MODIFY && it.price == PRICE_UNDEF) rsn = RSN_PRICE;
            else if (it.op == OP_MODIFY && it.size == 0) rsn = RSN_QUANTITY;
            else bad = 1'b0;
        end
        r.eng = it.eng; r.oid = it.oid; r.inst = it.inst;
        r.side = it.side; r.price = it.price;
        if (bad) begin
            r.kind = KIND_REJECT; r.reason = rsn; r.status = ST_REJECTED;
            r.orig = it.size;
            return 1'b1;
        end
        if (it.op == OP_NEW) begin
            s = tbl_used;
            tbl_used++;
            tbl_valid[s] = 1'b1; tbl_eng[s] = it.eng; tbl_oid[s] = it.oid;
            tbl_inst[s] = it.inst;
        end
        if (it.op == OP_CANCEL) begin
            tbl_status[s] = ST_CANCELLED;
            r.kind = KIND_CANCEL_ACK; r.status = ST_CANCELLED;
            r.orig = tbl_orig[s]; r.rem = tbl_rem[s];
            return 1'b1;
        end
        tbl_side[s] = it.side; tbl_price[s] = it.price;
        tbl_orig[s] = it.size; tbl_rem[s] = it.size; tbl_status[s] = ST_ACCEPTED;
        r.kind = it.op == OP_NEW ? KIND_NEW_ACK : KIND_MODIFY_ACK;
        r.status = ST_ACCEPTED; r.orig = it.size; r.rem = it.size;
        return 1'b1;
    endfunction

    task automatic send_item(input t_item it);
        t_rsp r;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= it.op; req_ch.engine_id <= it.eng;
        req_ch.order_ref <= it.oid; req_ch.instr_code <= it.inst;
        req_ch.side <= it.side; req_ch.price <= it.price;
        req_ch.size <= it.size; req_ch.timestamp <= it.ts;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (apply_request(it, r)) pending_rsp.insert(pending_rsp.size(), r);
        @(negedge i_clk);
    endtask

    task automatic wait_empty();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (DEPTH + 20) @(negedge i_clk);
    endtask

    task automatic write_mask(input logic [7:0] m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.engine_enabled <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        eng_mask = m;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_item rand_item();
        t_item it;
        int    pick;
        it.op = 2'($urandom_range(3));
        it.eng = $urandom_range(99) < 85 ? 3'($urandom_range(3)) : 3'($urandom);
        pick = $urandom_range(99);
        if (known_oid.size() != 0 && pick < 70)
            it.oid = known_oid[$urandom_range(known_oid.size() - 1)];
        else if (pick < 85) it.oid = $urandom_range(40);
        else it.oid = $urandom;
        it.inst = $urandom_range(99) < 90 ? 16'($urandom_range(65535, 1)) : 16'($urandom);
        it.side = $urandom_range(99) < 90 ? 2'($urandom_range(2, 1)) : 2'($urandom);
        pick = $urandom_range(99);
        it.price = pick < 5 ? PRICE_UNDEF : pick < 10 ? 32'h7fff_ffff : 32'($urandom);
        pick = $urandom_range(99);
        it.size = pick < 5 ? 32'd0 : pick < 10 ? 32'hffff_ffff :
                  pick < 60 ? 32'($urandom_range(200, 1)) : 32'($urandom);
        it.ts = {32'($urandom), 32'($urandom)};
        if (it.op == OP_NEW && known_oid.size() < 64)
            known_oid.insert(known_oid.size(), it.oid);
        return it;
    endfunction

    function automatic t_item mk(input logic [1:0] op, input logic [2:0] eng,
                                 input logic [31:0] oid, input logic [15:0] inst,
                                 input logic [1:0] side, input logic [31:0] price,
                                 input logic [31:0] size, input logic [63:0] ts);
        mk = '{op, eng, oid, inst, side, price, size, ts};
    endfunction

    function automatic t_rsp rej(input logic [2:0] rsn, input t_item it);
        t_rsp r;
        r = '{KIND_REJECT, rsn, ST_REJECTED, it.eng, it.oid, it.inst, it.side,
              it.price, it.size, 32'd0, 32'd0, 32'd0};
        return r;
    endfunction

    t_row dir_rows [$];

    task automatic add_row(input t_item it, input logic has, input logic typed,
                           input t_rsp r);
        t_row row;
        row.item = it;
        row.has_rsp = has;
        row.typed = typed;
        row.rsp = r;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic build_rows();
        t_item a;
        a = mk(OP_NEW, 0, 32'hffff_ffff, 16'hffff, SIDE_ASK, 32'h7fff_ffff,
               32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
        add_row(a, 1'b1, 1'b1, '{KIND_NEW_ACK, 3'd0, ST_ACCEPTED, a.eng, a.oid,
            a.inst, a.side, a.price, a.size, a.size, 32'd0, 32'd0});
        add_row(a, 1'b1, 1'b1, rej(RSN_DUPLICATE, a));
        a = mk(OP_NEW, 0, 1, 0, SIDE_BID, 5, 5, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_INSTRUMENT, a));
        a = mk(OP_NEW, 0, 1, 1, 2'd0, 5, 5, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_SIDE, a));
        a = mk(OP_NEW, 0, 1, 1, 2'd3, 5, 5, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_SIDE, a));
        a = mk(OP_NEW, 0, 1, 1, SIDE_BID, PRICE_UNDEF, 5, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_PRICE, a));
        a = mk(OP_NEW, 0, 1, 1, SIDE_BID, 5, 0, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_QUANTITY, a));
        a = mk(OP_CANCEL, 0, 9, 1, SIDE_BID, 5, 5, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_UNKNOWN, a));
        a = mk(OP_MODIFY, 0, 9, 1, SIDE_BID, 5, 5, 0);
        add_row(a, 1'b1, 1'b1, rej(RSN_UNKNOWN, a));
        a = mk(OP_NEW, 7, 3, 1, SIDE_BID, 5, 5, 0);
        add_row(a, 1'b0, 1'b1, '0);
        add_row(mk(OP_FILL, 7, 3, 0, 0, 5, 5, 0), 1'b1, 1'b1,
            '{KIND_FILL_DROP, 3'd0, ST_REJECTED, 3'd7, 32'd3, 16'd0, 2'd0,
              32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(mk(OP_NEW, 1, 0, 1, SIDE_BID, 32'h8000_0001, 10, 1), 1'b1, 1'b0, '0);
        add_row(mk(OP_FILL, 1, 0, 0, 0, 7, 0, 2), 1'b1, 1'b0, '0);
        add_row(mk(OP_FILL, 1, 0, 0, 0, 7, 4, 2), 1'b1, 1'b0, '0);
        add_row(mk(OP_MODIFY, 1, 0, 9, 2'd0, 7, 4, 3), 1'b1, 1'b0, '0);
        add_row(mk(OP_MODIFY, 1, 0, 9, SIDE_ASK, PRICE_UNDEF, 4, 3), 1'b1, 1'b0, '0);
        add_row(mk(OP_MODIFY, 1, 0, 9, SIDE_ASK, 0, 0, 3), 1'b1, 1'b0, '0);
        add_row(mk(OP_MODIFY, 1, 0, 9, SIDE_ASK, 0, 20, 3), 1'b1, 1'b0, '0);
        add_row(mk(OP_FILL, 1, 0, 0, 0, -1, 32'hffff_ffff, 4), 1'b1, 1'b0, '0);
        add_row(mk(OP_FILL, 1, 0, 0, 0, -1, 1, 4), 1'b1, 1'b0, '0);
        add_row(mk(OP_CANCEL, 1, 0, 0, 0, 0, 0, 5), 1'b1, 1'b0, '0);
        add_row(mk(OP_NEW, 2, 4, 1, SIDE_BID, 1, 3, 5), 1'b1, 1'b0, '0);
        add_row(mk(OP_CANCEL, 2, 4, 0, 3, PRICE_UNDEF, 0, 5), 1'b1, 1'b0, '0);
        add_row(mk(OP_CANCEL, 2, 4, 0, 3, 0, 0, 5), 1'b1, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.response_kind, rsp_ch.rej_code, rsp_ch.order_status,
                    rsp_ch.out_engine_id, rsp_ch.out_order_ref, rsp_ch.out_instr_code,
                    rsp_ch.out_side, rsp_ch.order_price, rsp_ch.orig_qty,
                    rsp_ch.open_qty, rsp_ch.exec_price, rsp_ch.exec_qty};
            if (pending_rsp.size() == 0) begin
                report("unexpected item", got.oid, 32'd0);
            end else begin
                want = pending_rsp.pop_front();
                if (got.kind !== want.kind)
                    report("kind", 32'(got.kind), 32'(want.kind));
                if (got.reason !== want.reason)
                    report("reason", 32'(got.reason), 32'(want.reason));
                if (got.status !== want.status)
                    report("status", 32'(got.status), 32'(want.status));
                if (got.eng !== want.eng)
                    report("engine", 32'(got.eng), 32'(want.eng));
                if (got.oid !== want.oid) report("order id", got.oid, want.oid);
                if (got.inst !== want.inst)
                    report("instrument", 32'(got.inst), 32'(want.inst));
                if (got.side !== want.side)
                    report("side", 32'(got.side), 32'(want.side));
                if (got.price !== want.price) report("price", got.price, want.price);
                if (got.orig !== want.orig) report("original", got.orig, want.orig);
                if (got.rem !== want.rem) report("remaining", got.rem, want.rem);
                if (got.fprice !== want.fprice) report("fill price", got.fprice, want.fprice);
                if (got.fsize !== want.fsize) report("fill size", got.fsize, want.fsize);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        rsp_ch.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

    initial begin
        t_item it;
        int    phase;
        req_ch.valid = 1'b0; req_ch.operation = '0; req_ch.engine_id = '0;
        req_ch.order_ref = '0; req_ch.instr_code = '0; req_ch.side = '0;
        req_ch.price = '0; req_ch.size = '0; req_ch.timestamp = '0;
        cfg_ch.valid = 1'b0; cfg_ch.engine_enabled = '0;
        rsp_ch.ready = 1'b1;
        eng_mask = '0;
        tbl_used = 0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0; tbl_status[i] = ST_ACCEPTED; tbl_rem[i] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Disabled engines first: fills drop, others are silent.
        send_item(mk(OP_NEW, 0, 5, 1, SIDE_BID, 1, 1, 0));
        send_item(mk(OP_FILL, 0, 5, 0, 0, 1, 1, 0));
        drain();
        write_mask(8'h7f);
        build_rows();
        foreach (dir_rows[k]) begin
            if (dir_rows[k].typed) begin
                send_item(dir_rows[k].item);
                if (dir_rows[k].has_rsp) begin
                    pending_rsp.pop_back();
                    pending_rsp.insert(pending_rsp.size(), dir_rows[k].rsp);
                end
            end else begin
                send_item(dir_rows[k].item);
            end
        end
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin send_idle = 0; recv_stall = 0; write_mask(8'hff); end
                1: begin send_idle = 80; recv_stall = 0; write_mask(8'h0f); end
                2: begin send_idle = 0; recv_stall = 80; write_mask(8'h55); end
                3: begin send_idle = 6; recv_stall = 6; write_mask(8'hff); end
                4: begin send_idle = 0; recv_stall = 0; write_mask(8'hff); end
                default: begin send_idle = 6; recv_stall = 6; write_mask(8'h00); end
            endcase
            for (int n = 0; n < (phase == 4 ? 300 : 210); n++) begin
                it = rand_item();
                if (phase == 4 && n < 250) begin
                    it.op = OP_NEW; it.oid = 32'h1000 + n; it.inst = 1;
                    it.side = SIDE_BID; it.price = 1; it.size = 1; it.eng = 0;
                end
                send_item(it);
                if (n == 100) wait_empty();
            end
            drain();
        end
        write_mask(8'hff);
        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* order_state_table.f */
rtl/core/ost_pkg.sv
rtl/core/ost_if.sv
rtl/core/ost_front.sv
rtl/core/ost_queue.sv
rtl/core/ost_back.sv
rtl/core/order_state_table.sv
test/testbench.sv
